// ===== design/gallop_right_search_assert.svh =====
// ----------------------------------------------------------------------------
// Gallop right search assertion macros
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GALLOP_RIGHT_SEARCH_ASSERT_SVH
`define GALLOP_RIGHT_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gallop_right_search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gallop_right_search: next-cycle check failed");

`endif

// ===== design/grs_pkg.sv =====
// ----------------------------------------------------------------------------
// Gallop right search package
// Field widths, default sizes and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_BYTES_DEF   = 8;

    localparam int KEY_IN_W = 64;
    localparam int INDEX_W  = 10;
    localparam int LEN_W    = 4;
    localparam int COUNT_W  = 11;
    localparam int HINT_W   = 10;
    localparam int OFFSET_W = 11;

    // Search positions: counts reach 2047 and the gallop offset may overshoot
    // to twice that before it is clamped.
    localparam int POS_W = 12;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ADDR_HINT,
        ADDR_GALLOP,
        ADDR_MID
    } addr_sel_t;

    typedef struct packed {
        logic      wr_en;
        logic      load_query;
        logic      rd_en;
        addr_sel_t addr_sel;
        logic      start_gallop;
        logic      step_gallop;
        logic      set_bounds;
        logic      bin_update;
        logic      load_result;
    } cmd_t;

    typedef struct packed {
        logic ge;
        logic n_zero;
        logic cur_lt_max;
        logic lo_lt_hi;
        logic dir_right;
    } status_t;

endpackage

// ===== design/grs_req_if.sv =====
// ----------------------------------------------------------------------------
// Gallop right search request channel
// Valid/ready channel carrying table writes and insertion queries.
// ----------------------------------------------------------------------------
interface grs_req_if
    import grs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_IN_W-1:0] key_bytes;
    logic [LEN_W-1:0]    key_length;
    logic [COUNT_W-1:0]  element_count;
    logic [HINT_W-1:0]   hint;

    modport source (
        output valid, kind, entry_index, key_bytes, key_length, element_count, hint,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, key_bytes, key_length, element_count, hint,
        output ready
    );
endinterface

// ===== design/grs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Gallop right search response channel
// Valid/ready channel carrying the insertion offset of a query.
// ----------------------------------------------------------------------------
interface grs_rsp_if
    import grs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] insert_offset;

    modport source (
        output valid, insert_offset,
        input  ready
    );

    modport sink (
        input  valid, insert_offset,
        output ready
    );
endinterface

// ===== design/grs_ram.sv =====
// ----------------------------------------------------------------------------
// Gallop right search RAM
// Generic simple dual-port memory: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module grs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/grs_datapath.sv =====
// ----------------------------------------------------------------------------
// Gallop right search datapath
// Key table, query registers, gallop and binary-search bounds, key compare
// and the result register.
// ----------------------------------------------------------------------------
module grs_datapath
    import grs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
    input  logic                clk,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [KEY_IN_W-1:0] key_bytes,
    input  logic [LEN_W-1:0]    key_length,
    input  logic [COUNT_W-1:0]  element_count,
    input  logic [HINT_W-1:0]   hint,
    output logic [OFFSET_W-1:0] insert_offset
);

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int ENT_W  = KEY_W + LEN_W;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);

    logic [KEY_W-1:0]    key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [POS_W-1:0]    n_reg;
    logic [POS_W-1:0]    h_reg;
    logic [POS_W-1:0]    cur_reg;
    logic [POS_W-1:0]    prev_reg;
    logic [POS_W-1:0]    maxo_reg;
    logic [POS_W-1:0]    lo_reg;
    logic [POS_W-1:0]    hi_reg;
    logic                dir_right_reg;
    logic [OFFSET_W-1:0] offset_reg;

    logic [LEN_W-1:0]    len_clip;
    logic [POS_W-1:0]    n_in;
    logic [POS_W-1:0]    hint_pos;
    logic [POS_W-1:0]    h_in;
    logic                wr_ok;
    logic [ENT_W-1:0]    ram_wdata;
    logic [ENT_W-1:0]    ram_rdata;
    logic [POS_W-1:0]    gal_pos;
    logic [POS_W-1:0]    mid;
    logic [POS_W-1:0]    rd_pos;
    logic [POS_W-1:0]    cur_clamp;

    logic [KEY_W-1:0]    ent_key;
    logic [LEN_W-1:0]    ent_len;
    logic [LEN_W-1:0]    span;
    logic                found;
    logic                ge;
    logic [7:0]          byte_q;
    logic [7:0]          byte_e;

    // Lengths beyond the key size saturate, both on store and on query.
    assign len_clip = (key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_length;
    assign n_in     = (32'(element_count) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH)
                                                         : POS_W'(element_count);
    assign hint_pos = POS_W'(hint);
    assign h_in     = (hint_pos >= n_in) ? n_in - POS_W'(1) : hint_pos;
    assign wr_ok    = 32'(entry_index) < TABLE_DEPTH;

    assign ram_wdata = {len_clip, key_bytes[KEY_IN_W-1 -: KEY_W]};

    assign gal_pos   = dir_right_reg ? h_reg + cur_reg : h_reg - cur_reg;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cur_clamp = (cur_reg < maxo_reg) ? cur_reg : maxo_reg;

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_HINT:   rd_pos = h_reg;
            ADDR_GALLOP: rd_pos = gal_pos;
            ADDR_MID:    rd_pos = mid;
            default:     rd_pos = mid;
        endcase
    end

    grs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_en && wr_ok),
        .waddr (IDX_W'(entry_index)),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (IDX_W'(rd_pos)),
        .rdata (ram_rdata)
    );

    assign ent_key = ram_rdata[KEY_W-1:0];
    assign ent_len = ram_rdata[KEY_W +: LEN_W];
    assign span    = (len_reg < ent_len) ? len_reg : ent_len;

    // The first differing byte within the shorter length decides; a shared
    // prefix, including an empty one, counts as equal.
    always_comb
    begin
        found  = 1'b0;
        ge     = 1'b1;
        byte_q = '0;
        byte_e = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            byte_q = key_reg[KEY_W-1-8*i -: 8];
            byte_e = ent_key[KEY_W-1-8*i -: 8];
            if (!found && (LEN_W'(i) < span) && (byte_q != byte_e))
            begin
                found = 1'b1;
                ge    = byte_q > byte_e;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            key_reg <= key_bytes[KEY_IN_W-1 -: KEY_W];
            len_reg <= len_clip;
            n_reg   <= n_in;
            h_reg   <= h_in;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end
        if (cmd.start_gallop)
        begin
            dir_right_reg <= ge;
            cur_reg       <= POS_W'(1);
            prev_reg      <= '0;
            maxo_reg      <= ge ? n_reg - h_reg : h_reg + POS_W'(1);
        end
        if (cmd.step_gallop)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= {cur_reg[POS_W-2:0], 1'b1};
        end
        if (cmd.set_bounds)
        begin
            if (dir_right_reg)
            begin
                lo_reg <= h_reg + prev_reg + POS_W'(1);
                hi_reg <= h_reg + cur_clamp;
            end
            else
            begin
                lo_reg <= h_reg + POS_W'(1) - cur_clamp;
                hi_reg <= h_reg - prev_reg;
            end
        end
        if (cmd.bin_update)
        begin
            if (ge)
            begin
                lo_reg <= mid + POS_W'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.load_result)
        begin
            offset_reg <= hi_reg[OFFSET_W-1:0];
        end
    end

    assign status.ge         = ge;
    assign status.n_zero     = (n_reg == '0);
    assign status.cur_lt_max = cur_reg < maxo_reg;
    assign status.lo_lt_hi   = lo_reg < hi_reg;
    assign status.dir_right  = dir_right_reg;

    assign insert_offset = offset_reg;

endmodule

// ===== design/grs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Gallop right search controller
// Sequences the hint compare, the gallop, the binary search and the hand-off
// of each result to the output register.
// ----------------------------------------------------------------------------
module grs_ctrl
    import grs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    req_kind,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [2:0] {
        IDLE,
        HINT_RD,
        HINT_EV,
        GAL_CHK,
        GAL_EV,
        BIN_CHK,
        BIN_EV,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   gal_stop;

    // The gallop ends at the first entry on the far side of the key.
    assign gal_stop = status.dir_right ? !status.ge : status.ge;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.addr_sel   = ADDR_HINT;
        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    if (req_kind == KIND_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = HINT_RD;
                    end
                end
            end
            HINT_RD:
            begin
                if (status.n_zero)
                begin
                    state_next = FINISH;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_HINT;
                    state_next   = HINT_EV;
                end
            end
            HINT_EV:
            begin
                cmd.start_gallop = 1'b1;
                state_next       = GAL_CHK;
            end
            GAL_CHK:
            begin
                if (status.cur_lt_max)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_GALLOP;
                    state_next   = GAL_EV;
                end
                else
                begin
                    cmd.set_bounds = 1'b1;
                    state_next     = BIN_CHK;
                end
            end
            GAL_EV:
            begin
                if (gal_stop)
                begin
                    cmd.set_bounds = 1'b1;
                    state_next     = BIN_CHK;
                end
                else
                begin
                    cmd.step_gallop = 1'b1;
                    state_next      = GAL_CHK;
                end
            end
            BIN_CHK:
            begin
                if (status.lo_lt_hi)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_MID;
                    state_next   = BIN_EV;
                end
                else
                begin
                    state_next = FINISH;
                end
            end
            BIN_EV:
            begin
                cmd.bin_update = 1'b1;
                state_next     = BIN_CHK;
            end
            FINISH:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// ===== design/gallop_right_search.sv =====
// ----------------------------------------------------------------------------
// Gallop right search
// Sorted byte-string key table answering insertion queries by a gallop from
// a hint followed by a binary search.
// ----------------------------------------------------------------------------
// Channel  Modport  Transfer carries
// req      sink     table write (kind 0) or insertion query (kind 1)
// rsp      source   insert_offset, one per query, none per write
//
// A write is taken in IDLE and leaves the controller idle. A query with a zero
// count goes straight to FINISH; any other query compares at the hint, then
// gallops and searches, each compare waiting for one registered RAM read.
// Reset clears only the controller; the table is undefined until written.
// A finished result waits in the output register while the next transfer on
// req is taken; a query only stalls in FINISH, while that register is full.
// ----------------------------------------------------------------------------
`include "gallop_right_search_assert.svh"

module gallop_right_search
    import grs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    grs_req_if.sink   req,
    grs_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    grs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    grs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .status        (status),
        .entry_index   (req.entry_index),
        .key_bytes     (req.key_bytes),
        .key_length    (req.key_length),
        .element_count (req.element_count),
        .hint          (req.hint),
        .insert_offset (rsp.insert_offset)
    );

    // A new result is only loaded when the output register is free or drains.
    `GRS_ASSERT_NOW(a_result_slot_free, cmd.load_result, !rsp.valid || rsp.ready)
    // The table is written only on an accepted write transfer.
    `GRS_ASSERT_NOW(a_write_on_transfer, cmd.wr_en,
        req.valid && req.ready && (req.kind == KIND_WRITE))
    // Once a query is taken the block is busy in the following cycle.
    `GRS_ASSERT_NEXT(a_busy_after_query,
        req.valid && req.ready && (req.kind == KIND_QUERY), !req.ready)

endmodule

// ===== bench/gallop_right_search_tb.sv =====
// ----------------------------------------------------------------------------
// Gallop right search testbench
// Fills the key table with sorted byte-string keys and sends insertion
// queries. A scoreboard works out each insert offset on its own copy of the
// table, and every response transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module gallop_right_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grs_pkg::*;

    typedef struct {
        logic                kind;
        logic [INDEX_W-1:0]  entry_index;
        logic [KEY_IN_W-1:0] key_bytes;
        logic [LEN_W-1:0]    key_length;
        logic [COUNT_W-1:0]  element_count;
        logic [HINT_W-1:0]   hint;
    } grs_item_t;

    class insert_tracker;
        logic [KEY_IN_W-1:0] table_keys [TABLE_DEPTH_DEF];
        int unsigned         table_lens [TABLE_DEPTH_DEF];
        logic [OFFSET_W-1:0] pending_offsets [$];
        int                  mismatches;

        static function int unsigned clip_len(logic [LEN_W-1:0] len);
            return (len > KEY_BYTES_DEF) ? KEY_BYTES_DEF : int'(len);
        endfunction

        // Orders the query key against one entry over the shorter length.
        function int order_to(logic [KEY_IN_W-1:0] key, int unsigned len, int unsigned idx);
            int unsigned span;
            logic [7:0]  a;
            logic [7:0]  b;
            span = (len < table_lens[idx]) ? len : table_lens[idx];
            for (int unsigned i = 0; i < span; i++)
            begin
                a = key[63 - 8*i -: 8];
                b = table_keys[idx][63 - 8*i -: 8];
                if (a != b)
                    return (a < b) ? -1 : 1;
            end
            return 0;
        endfunction

        function logic [OFFSET_W-1:0] gallop_offset(grs_item_t it);
            int unsigned n, h, cur, prev, lo, hi, maxo, mid, len;
            len = clip_len(it.key_length);
            n = it.element_count;
            if (n > TABLE_DEPTH_DEF)
                n = TABLE_DEPTH_DEF;
            if (n == 0)
                return '0;
            h = it.hint;
            if (h >= n)
                h = n - 1;
            cur = 1;
            prev = 0;
            if (order_to(it.key_bytes, len, h) >= 0)
            begin
                maxo = n - h;
                while (cur < maxo)
                begin
                    if (order_to(it.key_bytes, len, h + cur) < 0)
                        break;
                    prev = cur;
                    cur = cur * 2 + 1;
                end
                if (cur > maxo)
                    cur = maxo;
                lo = h + prev + 1;
                hi = h + cur;
            end
            else
            begin
                maxo = h + 1;
                while (cur < maxo)
                begin
                    if (order_to(it.key_bytes, len, h - cur) >= 0)
                        break;
                    prev = cur;
                    cur = cur * 2 + 1;
                end
                if (cur > maxo)
                    cur = maxo;
                lo = h + 1 - cur;
                hi = h - prev;
            end
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (order_to(it.key_bytes, len, mid) >= 0)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return hi[OFFSET_W-1:0];
        endfunction

        function void note_transfer(grs_item_t it);
            if (it.kind == KIND_WRITE)
            begin
                table_keys[it.entry_index] = it.key_bytes;
                table_lens[it.entry_index] = clip_len(it.key_length);
            end
            else
                pending_offsets.push_back(gallop_offset(it));
        endfunction

        function void check_offset(logic [OFFSET_W-1:0] got);
            logic [OFFSET_W-1:0] want;
            if (pending_offsets.size() == 0)
            begin
                $display("%0t: insert_offset with no query waiting, expected none, got %0d",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_offsets.pop_front();
            if (got !== want)
            begin
                $display("%0t: insert_offset mismatch, expected %0d, got %0d",
                         $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    grs_req_if req ();
    grs_rsp_if rsp ();

    gallop_right_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    insert_tracker tracker = new();

    bit          steady;
    bit          written [TABLE_DEPTH_DEF];
    int unsigned filled;
    int unsigned sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("** gallop_right_search: FAILED **");
        $finish;
    end

    // Response side: checks each transfer and, outside steady phases, stalls at random.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                tracker.check_offset(rsp.insert_offset);
            rsp.ready <= steady || ($urandom_range(0, 99) >= 12);
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h41;
            3: return 8'h42;
            4: return 8'h43;
            5: return 8'h7F;
            6: return 8'h80;
            7: return 8'hFE;
            8: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // A small alphabet makes shared prefixes and ties common.
    function automatic logic [KEY_IN_W-1:0] make_key();
        logic [KEY_IN_W-1:0] k;
        if ($urandom_range(0, 7) == 0)
            return {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
            k[63 - 8*i -: 8] = pick_byte();
        return k;
    endfunction

    function automatic logic [LEN_W-1:0] make_len();
        if ($urandom_range(0, 15) < 13)
            return LEN_W'($urandom_range(0, 8));
        return LEN_W'($urandom_range(9, 15));
    endfunction

    // Lexicographic rank over the valid bytes, the shorter key first on a tie.
    function automatic logic [67:0] sort_rank(logic [KEY_IN_W-1:0] key, logic [LEN_W-1:0] len);
        int unsigned         l;
        logic [KEY_IN_W-1:0] mask;
        l = insert_tracker::clip_len(len);
        mask = (l == 0) ? '0 : ({KEY_IN_W{1'b1}} << (64 - 8*l));
        return {key & mask, 4'(l)};
    endfunction

    function automatic grs_item_t write_item(int unsigned idx, logic [KEY_IN_W-1:0] key,
                                             logic [LEN_W-1:0] len);
        grs_item_t it;
        it.kind          = KIND_WRITE;
        it.entry_index   = INDEX_W'(idx);
        it.key_bytes     = key;
        it.key_length    = len;
        it.element_count = COUNT_W'($urandom);
        it.hint          = HINT_W'($urandom);
        return it;
    endfunction

    function automatic grs_item_t query_item(logic [KEY_IN_W-1:0] key, logic [LEN_W-1:0] len,
                                             int unsigned count, int unsigned start);
        grs_item_t it;
        it.kind          = KIND_QUERY;
        it.entry_index   = INDEX_W'($urandom);
        it.key_bytes     = key;
        it.key_length    = len;
        it.element_count = COUNT_W'(count);
        it.hint          = HINT_W'(start);
        return it;
    endfunction

    task automatic push(input grs_item_t it);
        if (!steady && $urandom_range(0, 99) < 12)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.kind          <= it.kind;
        req.entry_index   <= it.entry_index;
        req.key_bytes     <= it.key_bytes;
        req.key_length    <= it.key_length;
        req.element_count <= it.element_count;
        req.hint          <= it.hint;
        do @(posedge clk); while (!req.ready);
        tracker.note_transfer(it);
        sent++;
        if (it.kind == KIND_WRITE)
        begin
            written[it.entry_index] = 1'b1;
            while (filled < TABLE_DEPTH_DEF && written[filled])
                filled++;
        end
    endtask

    // Always lets a clock edge pass before it checks, so that the request lines are never
    // driven twice in the same time step around a pause.
    task automatic wait_results_drained();
        do @(posedge clk); while (tracker.pending_offsets.size() != 0);
    endtask

    // Writes entries 0 to m-1 with freshly sorted keys.
    task automatic fill_table(int unsigned m);
        logic [KEY_IN_W-1:0] keys [];
        logic [LEN_W-1:0]    lens [];
        logic [KEY_IN_W-1:0] k;
        logic [LEN_W-1:0]    l;
        int                  j;
        keys = new[m];
        lens = new[m];
        for (int i = 0; i < m; i++)
        begin
            keys[i] = make_key();
            lens[i] = make_len();
        end
        for (int i = 1; i < m; i++)
        begin
            k = keys[i];
            l = lens[i];
            j = i;
            while (j > 0 && sort_rank(keys[j-1], lens[j-1]) > sort_rank(k, l))
            begin
                keys[j] = keys[j-1];
                lens[j] = lens[j-1];
                j--;
            end
            keys[j] = k;
            lens[j] = l;
        end
        for (int i = 0; i < m; i++)
            push(write_item(i, keys[i], lens[i]));
    endtask

    task automatic run_directed();
        // Sorted six-entry table with an empty key, garbage past the length,
        // an overlong length and an all-ones key, also written to the last entry.
        push(write_item(0, 64'h0, 4'd0));
        push(write_item(1, 64'h00FF_FFFF_FFFF_FFFF, 4'd1));
        push(write_item(2, 64'h4100_0000_0000_0000, 4'd1));
        push(write_item(3, 64'h4142_9999_0000_1234, 4'd2));
        push(write_item(4, 64'h41FF_0000_0000_0000, 4'd15));
        push(write_item(5, {KEY_IN_W{1'b1}}, 4'd8));
        push(write_item(TABLE_DEPTH_DEF - 1, {KEY_IN_W{1'b1}}, 4'd8));

        push(query_item(64'h4100_0000_0000_0000, 4'd1, 0, 1023));
        push(query_item(64'h4100_0000_0000_0000, 4'd1, 1, 0));
        push(query_item({KEY_IN_W{1'b1}}, 4'd8, 6, 1023));
        push(query_item(64'h0, 4'd0, 6, 0));
        push(query_item(64'h0, 4'd8, 6, 5));
        push(query_item(64'h4100_0000_0000_0000, 4'd15, 6, 2));
        push(query_item(64'h4142_0000_0000_0000, 4'd2, 6, 3));
        push(query_item(64'h4200_0000_0000_0000, 4'd1, 5, 4));
        push(query_item({KEY_IN_W{1'b1}}, 4'd15, 6, 0));
        push(query_item(64'h4000_0000_0000_0000, 4'd1, 2, 1));
        push(query_item(64'h0000_0000_0000_0001, 4'd8, 6, 5));
        push(query_item(64'h41FF_0000_0000_0000, 4'd8, 6, 4));
        push(query_item(64'h0, 4'd0, 1, 1023));
    endtask

    task automatic run_random();
        int unsigned         phase;
        int unsigned         m;
        int unsigned         nq;
        int unsigned         count;
        int unsigned         start;
        int unsigned         pick;
        logic [KEY_IN_W-1:0] key;
        logic [LEN_W-1:0]    len;
        phase = 0;
        while (sent < 1900)
        begin
            steady = (phase >= 3 && phase < 6);
            if (phase == 0)
                m = TABLE_DEPTH_DEF;
            else if ($urandom_range(0, 7) == 0)
                m = $urandom_range(33, 300);
            else
                m = $urandom_range(1, 32);
            fill_table(m);
            nq = $urandom_range(10, 40);
            for (int q = 0; q < nq; q++)
            begin
                // A stray write now and then leaves the table out of order.
                if ($urandom_range(0, 9) == 0)
                    push(write_item($urandom_range(0, m - 1), make_key(), make_len()));
                case ($urandom_range(0, 9))
                    0: count = 0;
                    1: count = $urandom_range(0, filled);
                    2: count = (filled == TABLE_DEPTH_DEF) ? $urandom_range(1025, 2047) : m;
                    default: count = m;
                endcase
                if (count > 0 && $urandom_range(0, 9) < 7)
                    start = $urandom_range(0, count - 1);
                else
                    start = $urandom_range(0, 1023);
                if ($urandom_range(0, 1) == 0)
                begin
                    pick = $urandom_range(0, m - 1);
                    key = tracker.table_keys[pick];
                    len = LEN_W'(tracker.table_lens[pick]);
                    if ($urandom_range(0, 2) == 0)
                        len = make_len();
                    if ($urandom_range(0, 2) == 0)
                        key = key ^ (64'h1 << $urandom_range(0, 63));
                end
                else
                begin
                    key = make_key();
                    len = make_len();
                end
                push(query_item(key, len, count, start));
            end
            phase++;
            if (phase == 1 || $urandom_range(0, 2) == 0)
            begin
                req.valid <= 1'b0;
                wait_results_drained();
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.kind          <= KIND_WRITE;
        req.entry_index   <= '0;
        req.key_bytes     <= '0;
        req.key_length    <= '0;
        req.element_count <= '0;
        req.hint          <= '0;
        steady = 1'b0;
        filled = 0;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req.valid <= 1'b0;
        wait_results_drained();
        repeat (60) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_offsets.size() == 0)
            $display("** gallop_right_search: PASSED **");
        else
            $display("** gallop_right_search: FAILED **");
        $finish;
    end

endmodule
